>>> rtl/core/pwmadb_pkg.sv
// Shared types and constants for the PWM audio double-buffer player.
// No dependencies; used by the top level and the sample memory.
`default_nettype none

package pwmadb_pkg;

    // Field widths
    localparam int OP_W       = 2;
    localparam int ADDR_W     = 10;
    localparam int SAMPLE_W   = 8;
    localparam int COUNT_W    = 16;
    localparam int PRESCALE_W = 16;
    localparam int HOLD_W     = 4;
    localparam int STEP_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_REFILL = 2'd2;
    localparam logic [OP_W-1:0] OP_START  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PRESCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_PERIODS  = 1'b1;

    // Configuration reset values
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd13;
    localparam logic [HOLD_W-1:0]     HOLD_RESET     = 4'd3;

    // State snapshot carried alongside the sample read
    typedef struct packed {
        logic              playing;
        logic [STEP_W-1:0] step;
        logic              pending;
        logic              refill_bank;
        logic              underrun;
    } snapshot_t;

endpackage

`default_nettype wire

>>> rtl/core/pwm_audio_double_buffer_player.sv
// Top level of the PWM audio double-buffer player: control state,
// result pipeline and configuration. Depends on pwmadb_pkg, pwmadb_sample_mem.
`default_nettype none

// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------------
// in       | in_valid/in_ready   | operation, bank, address, sample_data,
//          |                     | bank_count
// out      | out_valid/out_ready | pwm_level, drive_enable, refill_request,
//          |                     | refill_bank, underrun
// cfg      | cfg_we              | cfg_index, cfg_data
//
// One transaction per cycle sustained while the output is not stalled; a result
// passes the read stage (the registered read port of the sample memory), then the output register.
// Control state updates at accept; the sample at the new play position is
// read in the same cycle and compared against the step count when the read stage advances.
// Reset clears control state only; the sample store holds no reset value.
// A stalled output backs up through the read stage to in_ready.

module pwm_audio_double_buffer_player #(
    parameter int BANK_DEPTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [pwmadb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pwmadb_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [pwmadb_pkg::OP_W-1:0]       operation,
    input  wire logic                              bank,
    input  wire logic [pwmadb_pkg::ADDR_W-1:0]     address,
    input  wire logic [pwmadb_pkg::SAMPLE_W-1:0]   sample_data,
    input  wire logic [pwmadb_pkg::COUNT_W-1:0]    bank_count,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   pwm_level,
    output logic                                   drive_enable,
    output logic                                   refill_request,
    output logic                                   refill_bank,
    output logic                                   underrun
);

    localparam int IW = $clog2(BANK_DEPTH);
    localparam logic [IW-1:0] LAST_INDEX  = IW'(BANK_DEPTH - 1);
    localparam logic [16:0]   DEPTH_LIMIT = 17'(BANK_DEPTH);

    // Configuration registers
    logic [pwmadb_pkg::PRESCALE_W-1:0] step_prescale_reg;
    logic [pwmadb_pkg::HOLD_W-1:0]     hold_periods_reg;

    // Player state
    logic                              playing_reg, playing_next;
    logic                              play_bank_reg, play_bank_next;
    logic [IW-1:0]                     play_index_reg, play_index_next;
    logic [pwmadb_pkg::HOLD_W-1:0]     hold_counter_reg, hold_counter_next;
    logic [pwmadb_pkg::STEP_W-1:0]     step_counter_reg, step_counter_next;
    logic [pwmadb_pkg::PRESCALE_W-1:0] prescale_counter_reg, prescale_counter_next;
    logic                              refill_pending_reg, refill_pending_next;
    logic [pwmadb_pkg::COUNT_W-1:0]    remaining_banks_reg, remaining_banks_next;
    logic                              underrun_reg, underrun_next;

    // Pipeline
    logic                              s1_valid_reg;
    pwmadb_pkg::snapshot_t             s1_snap_reg;
    logic                              out_valid_reg;
    logic                              s1_advance;
    logic                              in_fire;

    // Datapath helpers
    logic [pwmadb_pkg::PRESCALE_W-1:0] prescale_eff;
    logic [pwmadb_pkg::HOLD_W-1:0]     hold_eff;
    logic [pwmadb_pkg::PRESCALE_W:0]   prescale_sum;
    logic [pwmadb_pkg::HOLD_W:0]       hold_sum;
    logic [IW+pwmadb_pkg::ADDR_W-1:0]  addr_wide;
    logic [IW-1:0]                     write_index;
    logic                              write_en;
    logic [pwmadb_pkg::SAMPLE_W-1:0]   sample_q;

    // Handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_prescale_reg <= pwmadb_pkg::PRESCALE_RESET;
            hold_periods_reg  <= pwmadb_pkg::HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwmadb_pkg::CFG_STEP_PRESCALE: step_prescale_reg <= cfg_data;
                pwmadb_pkg::CFG_HOLD_PERIODS:
                    hold_periods_reg <= cfg_data[pwmadb_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero in either register acts as one
    assign prescale_eff = (step_prescale_reg == '0) ? 16'd1 : step_prescale_reg;
    assign hold_eff     = (hold_periods_reg == '0) ? 4'd1 : hold_periods_reg;
    assign prescale_sum = {1'b0, prescale_counter_reg} + 17'd1;
    assign hold_sum     = {1'b0, hold_counter_reg} + 5'd1;

    // Write index, resized to the bank index width
    assign addr_wide   = {{IW{1'b0}}, address};
    assign write_index = addr_wide[IW-1:0];

    // Next-state logic for one transaction
    always_comb
    begin
        playing_next          = playing_reg;
        play_bank_next        = play_bank_reg;
        play_index_next       = play_index_reg;
        hold_counter_next     = hold_counter_reg;
        step_counter_next     = step_counter_reg;
        prescale_counter_next = prescale_counter_reg;
        refill_pending_next   = refill_pending_reg;
        remaining_banks_next  = remaining_banks_reg;
        underrun_next         = underrun_reg;
        write_en              = 1'b0;
        unique case (operation)
            pwmadb_pkg::OP_TICK:
            begin
                if (playing_reg)
                begin
                    if (prescale_sum < {1'b0, prescale_eff})
                    begin
                        prescale_counter_next = prescale_sum[pwmadb_pkg::PRESCALE_W-1:0];
                    end
                    else
                    begin
                        prescale_counter_next = '0;
                        step_counter_next     = step_counter_reg + 8'd1;
                        if (step_counter_reg == 8'hFF)
                        begin
                            if (hold_sum < {1'b0, hold_eff})
                            begin
                                hold_counter_next = hold_sum[pwmadb_pkg::HOLD_W-1:0];
                            end
                            else
                            begin
                                hold_counter_next = '0;
                                // advance to the next sample
                                priority if (play_index_reg != LAST_INDEX)
                                begin
                                    play_index_next = play_index_reg + 1'b1;
                                end
                                else if (remaining_banks_reg == '0)
                                begin
                                    playing_next        = 1'b0;
                                    refill_pending_next = 1'b0;
                                end
                                else if (refill_pending_reg)
                                begin
                                    underrun_next = 1'b1;
                                end
                                else
                                begin
                                    refill_pending_next = 1'b1;
                                    underrun_next       = 1'b0;
                                    play_index_next     = '0;
                                    play_bank_next      = ~play_bank_reg;
                                end
                            end
                        end
                    end
                end
            end
            pwmadb_pkg::OP_WRITE:
            begin
                write_en = ({7'd0, address} < DEPTH_LIMIT);
            end
            pwmadb_pkg::OP_REFILL:
            begin
                if (refill_pending_reg)
                begin
                    refill_pending_next = 1'b0;
                    if (remaining_banks_reg != '0)
                    begin
                        remaining_banks_next = remaining_banks_reg - 16'd1;
                    end
                end
            end
            pwmadb_pkg::OP_START:
            begin
                playing_next          = 1'b1;
                play_bank_next        = 1'b0;
                play_index_next       = '0;
                hold_counter_next     = '0;
                step_counter_next     = '0;
                prescale_counter_next = '0;
                refill_pending_next   = 1'b0;
                underrun_next         = 1'b0;
                remaining_banks_next  = bank_count;
            end
            default: ;
        endcase
    end

    // Player state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg          <= 1'b0;
            play_bank_reg        <= 1'b0;
            play_index_reg       <= '0;
            hold_counter_reg     <= '0;
            step_counter_reg     <= '0;
            prescale_counter_reg <= '0;
            refill_pending_reg   <= 1'b0;
            remaining_banks_reg  <= '0;
            underrun_reg         <= 1'b0;
        end
        else if (in_fire)
        begin
            playing_reg          <= playing_next;
            play_bank_reg        <= play_bank_next;
            play_index_reg       <= play_index_next;
            hold_counter_reg     <= hold_counter_next;
            step_counter_reg     <= step_counter_next;
            prescale_counter_reg <= prescale_counter_next;
            refill_pending_reg   <= refill_pending_next;
            remaining_banks_reg  <= remaining_banks_next;
            underrun_reg         <= underrun_next;
        end
    end

    // Sample store; reads the sample at the updated play position
    pwmadb_sample_mem #(
        .MEM_ADDR_W (IW + 1)
    ) u_sample_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (in_fire && write_en),
        .waddr ({bank, write_index}),
        .wdata (sample_data),
        .re    (in_fire),
        .raddr ({play_bank_next, play_index_next}),
        .rdata (sample_q)
    );

    // Read stage: state snapshot waiting for the sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_snap_reg.playing     <= playing_next;
            s1_snap_reg.step        <= step_counter_next;
            s1_snap_reg.pending     <= refill_pending_next;
            s1_snap_reg.refill_bank <= ~play_bank_next;
            s1_snap_reg.underrun    <= underrun_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            pwm_level      <= s1_snap_reg.playing && (s1_snap_reg.step < sample_q);
            drive_enable   <= s1_snap_reg.playing;
            refill_request <= s1_snap_reg.pending;
            refill_bank    <= s1_snap_reg.refill_bank;
            underrun       <= s1_snap_reg.underrun;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    // Counters rest at zero whenever playback is stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        !playing_reg |-> (prescale_counter_reg == '0) && (step_counter_reg == '0)
                         && (hold_counter_reg == '0))
        else $error("counters not cleared while stopped");

    // A released pin never shows PWM or a refill request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !drive_enable |-> !pwm_level && !refill_request)
        else $error("output active while pin released");

    // Refill pending only arises while playing
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(refill_pending_reg) |-> playing_reg && $past(playing_reg))
        else $error("refill requested while stopped");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pwmadb_sample_mem.sv
// Sample store: one write port, one registered read port, with
// same-cycle write-to-read forwarding. Depends on pwmadb_pkg.
`default_nettype none

module pwmadb_sample_mem #(
    parameter int MEM_ADDR_W = 11
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           we,
    input  wire logic [MEM_ADDR_W-1:0]          waddr,
    input  wire logic [pwmadb_pkg::SAMPLE_W-1:0] wdata,
    input  wire logic                           re,
    input  wire logic [MEM_ADDR_W-1:0]          raddr,
    output logic      [pwmadb_pkg::SAMPLE_W-1:0] rdata
);

    localparam int DEPTH = 2 ** MEM_ADDR_W;

    logic [pwmadb_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [pwmadb_pkg::SAMPLE_W-1:0] ram_q_reg;
    logic [pwmadb_pkg::SAMPLE_W-1:0] fwd_data_reg;
    logic                            fwd_reg;

    // Array: write, read-first registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            ram_q_reg    <= mem[raddr];
            fwd_data_reg <= wdata;
        end
    end

    // Forward a write that hits the address read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (re)
        begin
            fwd_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = fwd_reg ? fwd_data_reg : ram_q_reg;

endmodule

`default_nettype wire

>>> tb/tb_pwm_audio_double_buffer_player.sv
// Self-checking testbench for the PWM audio double-buffer player.
// Depends on pwmadb_pkg and the pwm_audio_double_buffer_player top level.

module tb_pwm_audio_double_buffer_player;
    timeunit 1ns;
    timeprecision 1ps;

    // Bank depth under test
    localparam int BANK_DEPTH    = 16;
    localparam int NUM_SESSIONS  = 3;
    localparam int SESSION_TICKS = 320;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_CYCLES  = 600;
    localparam int MAX_REPORTS   = 200;
    localparam int unsigned CYCLE_LIMIT = 200_000;

    typedef logic [pwmadb_pkg::ADDR_W-1:0]     addr_t;
    typedef logic [pwmadb_pkg::SAMPLE_W-1:0]   sample_t;
    typedef logic [pwmadb_pkg::COUNT_W-1:0]    count_t;
    typedef logic [pwmadb_pkg::CFG_DATA_W-1:0] cfg_data_t;

    typedef struct packed {
        logic [pwmadb_pkg::OP_W-1:0] op;
        logic                        bank_sel;
        addr_t                       addr;
        sample_t                     sample;
        count_t                      banks;
    } audio_op_t;

    typedef struct packed {
        logic pwm_level;
        logic drive_enable;
        logic refill_request;
        logic refill_bank;
        logic underrun;
    } pin_state_t;

    logic                                 clk;
    logic                                 rst_n     = 1'b0;
    logic                                 cfg_we    = 1'b0;
    logic [pwmadb_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    cfg_data_t                            cfg_data  = '0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_ready;
    audio_op_t                            offered   = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic                                 pwm_level;
    logic                                 drive_enable;
    logic                                 refill_request;
    logic                                 refill_bank;
    logic                                 underrun;

    // Stimulus backlog and expected pin states
    audio_op_t  op_backlog[$];
    pin_state_t expected_pins[$];
    pin_state_t want_pins;

    // Traffic shaping
    int unsigned send_idle_pct = 10;
    int unsigned recv_idle_pct = 69;
    logic        stall_request = 1'b0;
    logic        stall_done    = 1'b0;
    int unsigned stall_left    = 0;

    // Bookkeeping
    int unsigned cycle_count    = 0;
    int unsigned accepted_count = 0;
    int unsigned error_count    = 0;
    int unsigned advance_count  = 0;
    int unsigned swap_count     = 0;
    int unsigned underrun_count = 0;
    int unsigned stop_count     = 0;

    // Shadow configuration and playback state
    logic [pwmadb_pkg::PRESCALE_W-1:0] cfg_prescale = pwmadb_pkg::PRESCALE_RESET;
    logic [pwmadb_pkg::HOLD_W-1:0]     cfg_hold     = pwmadb_pkg::HOLD_RESET;
    sample_t                           sh_store [0:2*BANK_DEPTH-1];
    logic                              sh_bank      = 1'b0;
    int unsigned                       sh_index     = 0;
    logic [pwmadb_pkg::HOLD_W-1:0]     sh_hold      = '0;
    logic [pwmadb_pkg::STEP_W-1:0]     sh_step      = '0;
    logic [pwmadb_pkg::PRESCALE_W-1:0] sh_prescale  = '0;
    logic                              sh_pending   = 1'b0;
    count_t                            sh_remaining = '0;
    logic                              sh_playing   = 1'b0;
    logic                              sh_underrun  = 1'b0;

    pwm_audio_double_buffer_player #(
        .BANK_DEPTH(BANK_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (offered.op),
        .bank           (offered.bank_sel),
        .address        (offered.addr),
        .sample_data    (offered.sample),
        .bank_count     (offered.banks),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pwm_level      (pwm_level),
        .drive_enable   (drive_enable),
        .refill_request (refill_request),
        .refill_bank    (refill_bank),
        .underrun       (underrun)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the shadow player by one transaction and return the pin state after it
    function automatic pin_state_t predict_pin_state(audio_op_t it);
        int unsigned pre_eff;
        int unsigned hold_eff;
        pin_state_t  res;
        pre_eff  = (cfg_prescale == 0) ? 1 : cfg_prescale;
        hold_eff = (cfg_hold == 0) ? 1 : cfg_hold;
        unique case (it.op)
            pwmadb_pkg::OP_TICK:
            begin
                if (sh_playing)
                begin
                    sh_prescale = sh_prescale + 1'b1;
                    if (sh_prescale >= pre_eff)
                    begin
                        sh_prescale = '0;
                        sh_step = sh_step + 1'b1;
                        if (sh_step == 0)
                        begin
                            sh_hold = sh_hold + 1'b1;
                            if (sh_hold >= hold_eff)
                            begin
                                sh_hold = '0;
                                sh_index++;
                                advance_count++;
                                // end of bank: stop, underrun or swap
                                if (sh_index >= BANK_DEPTH)
                                begin
                                    if (sh_remaining == 0)
                                    begin
                                        sh_playing = 1'b0;
                                        sh_pending = 1'b0;
                                        sh_index   = BANK_DEPTH - 1;
                                        stop_count++;
                                    end
                                    else if (sh_pending)
                                    begin
                                        sh_underrun = 1'b1;
                                        sh_index    = BANK_DEPTH - 1;
                                        underrun_count++;
                                    end
                                    else
                                    begin
                                        sh_pending  = 1'b1;
                                        sh_underrun = 1'b0;
                                        sh_index    = 0;
                                        sh_bank     = ~sh_bank;
                                        swap_count++;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            pwmadb_pkg::OP_WRITE:
            begin
                if (it.addr < BANK_DEPTH)
                    sh_store[it.bank_sel * BANK_DEPTH + it.addr] = it.sample;
            end
            pwmadb_pkg::OP_REFILL:
            begin
                // acknowledge only counts while a refill is pending
                if (sh_pending)
                begin
                    sh_pending = 1'b0;
                    if (sh_remaining != 0)
                        sh_remaining = sh_remaining - 1'b1;
                end
            end
            pwmadb_pkg::OP_START:
            begin
                sh_playing   = 1'b1;
                sh_bank      = 1'b0;
                sh_index     = 0;
                sh_hold      = '0;
                sh_step      = '0;
                sh_prescale  = '0;
                sh_pending   = 1'b0;
                sh_underrun  = 1'b0;
                sh_remaining = it.banks;
            end
        endcase
        res.pwm_level      = sh_playing && (sh_step < sh_store[sh_bank * BANK_DEPTH + sh_index]);
        res.drive_enable   = sh_playing;
        res.refill_request = sh_pending;
        res.refill_bank    = ~sh_bank;
        res.underrun       = sh_underrun;
        return res;
    endfunction

    // Operation with random content in every other field
    function automatic audio_op_t random_op(logic [pwmadb_pkg::OP_W-1:0] op);
        audio_op_t it;
        it.op       = op;
        it.bank_sel = 1'($urandom_range(1));
        it.addr     = addr_t'($urandom_range(1023));
        it.sample   = sample_t'($urandom_range(255));
        it.banks    = count_t'($urandom_range(65535));
        return it;
    endfunction

    task automatic queue_write(logic bank_sel, addr_t addr, sample_t sample);
        audio_op_t it;
        it          = random_op(pwmadb_pkg::OP_WRITE);
        it.bank_sel = bank_sel;
        it.addr     = addr;
        it.sample   = sample;
        op_backlog.push_back(it);
    endtask

    task automatic queue_start(count_t banks);
        audio_op_t it;
        it       = random_op(pwmadb_pkg::OP_START);
        it.banks = banks;
        op_backlog.push_back(it);
    endtask

    task automatic queue_ticks(int unsigned n);
        repeat (n) op_backlog.push_back(random_op(pwmadb_pkg::OP_TICK));
    endtask

    // Register write; only called with nothing in flight
    task automatic write_reg(logic [pwmadb_pkg::CFG_IDX_W-1:0] idx, cfg_data_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == pwmadb_pkg::CFG_STEP_PRESCALE)
            cfg_prescale = value;
        else
            cfg_hold = value[pwmadb_pkg::HOLD_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for the backlog to drain and every result to come back
    task automatic wait_idle();
        @(posedge clk);
        while (op_backlog.size() != 0 || in_valid || expected_pins.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_pin(string what, logic want, logic got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %b, got %b", $time, what, want, got);
            else if (error_count == MAX_REPORTS + 1)
                $display("%0t ns: further mismatches counted, not printed", $time);
        end
    endtask

    // One playback session: config, start, a tick run with acks, writes, restarts
    task automatic run_session(bit arm_stall);
        int unsigned pick;
        int unsigned pre_set;
        int unsigned hold_set;
        int unsigned restart_at;
        int unsigned i;
        count_t      banks;
        addr_t       addr;
        pick     = $urandom_range(8);
        pre_set  = 1;
        hold_set = 1;
        if (pick == 6)
            pre_set = 2;
        else if (pick == 7)
            hold_set = 2;
        else if (pick == 8)
        begin
            // zero values behave as one
            pre_set  = 0;
            hold_set = 0;
        end
        write_reg(pwmadb_pkg::CFG_STEP_PRESCALE, cfg_data_t'(pre_set));
        write_reg(pwmadb_pkg::CFG_HOLD_PERIODS,
                  cfg_data_t'(($urandom_range(65535) & 32'hFFF0) | hold_set));

        pick = $urandom_range(9);
        if (pick < 2)
            banks = '0;
        else if (pick < 5)
            banks = count_t'(1);
        else if (pick < 8)
            banks = count_t'(2);
        else if (pick == 8)
            banks = count_t'(3);
        else
            banks = $urandom_range(1) ? '1 : count_t'($urandom_range(65535));

        restart_at = ($urandom_range(2) == 0) ? $urandom_range(SESSION_TICKS - 1)
                                              : SESSION_TICKS;

        queue_start(banks);
        for (i = 0; i < SESSION_TICKS; i++)
        begin
            if (i == restart_at)
                queue_start(count_t'($urandom_range(2)));
            op_backlog.push_back(random_op(pwmadb_pkg::OP_TICK));
            if ($urandom_range(31) == 0)
                op_backlog.push_back(random_op(pwmadb_pkg::OP_REFILL));
            if ($urandom_range(15) == 0)
            begin
                addr = ($urandom_range(7) == 0) ? addr_t'($urandom_range(1023))
                                                : addr_t'($urandom_range(BANK_DEPTH - 1));
                queue_write(1'($urandom_range(1)), addr, sample_t'($urandom_range(255)));
            end
        end
        if (arm_stall)
            stall_request <= 1'b1;
    endtask

    // Driver: offer backlog items, predict each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_pins.push_back(predict_pin_state(offered));
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered  <= op_backlog.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction, shape out_ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pins.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"%0t ns: result with no transaction outstanding, ",
                                  "expected none, got %b"},
                                 $time, {pwm_level, drive_enable, refill_request,
                                         refill_bank, underrun});
                end
                else
                begin
                    want_pins = expected_pins.pop_front();
                    check_pin("pwm_level", want_pins.pwm_level, pwm_level);
                    check_pin("drive_enable", want_pins.drive_enable, drive_enable);
                    check_pin("refill_request", want_pins.refill_request, refill_request);
                    check_pin("refill_bank", want_pins.refill_bank, refill_bank);
                    check_pin("underrun", want_pins.underrun, underrun);
                end
            end
            // long hold-off once, then random backpressure
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (stall_request && !stall_done)
            begin
                stall_left <= STALL_CYCLES;
                stall_done <= 1'b1;
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("pwm_audio_double_buffer_player regression: fail");
            $finish;
        end
    end

    initial
    begin : main_seq
        int unsigned b;
        int unsigned a;
        int unsigned s;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // fill both banks so playback never reads an unwritten entry
        for (b = 0; b < 2; b++)
            for (a = 0; a < BANK_DEPTH; a++)
                queue_write(1'(b), addr_t'(a),
                            (b == 0 && a == 0) ? 8'hFF :
                            (b == 0 && a == 1) ? 8'h00 : sample_t'($urandom_range(255)));

        // directed checks at reset configuration
        queue_write(1'b0, 10'h3FF, 8'hAA);                   // beyond the bank, dropped
        queue_write(1'b1, addr_t'(BANK_DEPTH), 8'h55);       // one past the bank end, dropped
        queue_write(1'b1, addr_t'(BANK_DEPTH - 2), 8'hFF);
        op_backlog.push_back(random_op(pwmadb_pkg::OP_TICK));   // tick while stopped
        op_backlog.push_back(random_op(pwmadb_pkg::OP_REFILL)); // ack with nothing pending
        queue_start(16'h0000);
        queue_ticks(3);
        queue_start(16'hFFFF);                               // restart while playing
        queue_write(1'b0, '0, 8'h00);                        // overwrite the sample now playing
        queue_ticks(3);
        wait_idle();

        // slowest settings
        write_reg(pwmadb_pkg::CFG_STEP_PRESCALE, 16'hFFFF);
        write_reg(pwmadb_pkg::CFG_HOLD_PERIODS, 16'h000F);
        queue_start(16'd2);
        queue_ticks(3);
        wait_idle();

        // zero settings act as one: step moves every tick
        write_reg(pwmadb_pkg::CFG_STEP_PRESCALE, 16'h0000);
        write_reg(pwmadb_pkg::CFG_HOLD_PERIODS, 16'hFFF0);
        queue_start(16'd1);
        queue_ticks(6);
        wait_idle();

        // random playback sessions in three traffic modes
        for (s = 0; s < NUM_SESSIONS; s++)
        begin
            if (s == NUM_SESSIONS / 3)
            begin
                send_idle_pct <= 69;
                recv_idle_pct <= 10;
            end
            else if (s == 2 * NUM_SESSIONS / 3)
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            run_session(s == 2 * NUM_SESSIONS / 3);
            wait_idle();
        end

        if (expected_pins.size() != 0)
        begin
            error_count++;
            $display("%0t ns: results missing, expected %0d more, got none",
                     $time, expected_pins.size());
        end
        $display("Ran %0d transactions: directed checks plus %0d playback sessions.",
                 accepted_count, NUM_SESSIONS);
        $display("Sample advances %0d, bank swaps %0d, underruns %0d, stops %0d; %0d errors.",
                 advance_count, swap_count, underrun_count, stop_count, error_count);
        if (error_count == 0)
            $display("pwm_audio_double_buffer_player regression: pass");
        else
            $display("pwm_audio_double_buffer_player regression: fail");
        $finish;
    end

endmodule
